// ===== src/lic_pkg.sv =====
// Shared types, command codes and arithmetic helpers for the LED image color crossfade block.
package lic_pkg;

    // Default number of matrix cells.
    localparam int CELLS_DEF = 256;

    // Command codes carried in the func field.
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_RENDER = 2'd3;

    // Full scale value for brightness, masks and factors.
    localparam logic [7:0] FULL_SCALE = 8'd255;

    // Input word.
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  cell_index;
        logic        cell_lit;
        logic [15:0] duration_ms;
        logic        blend_image;
        logic        blend_color;
        logic [7:0]  target_red;
        logic [7:0]  target_green;
        logic [7:0]  target_blue;
    } in_t;

    // Result word.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       busy_res;
        logic [7:0] blend_factor;
        logic       finished;
    } out_t;

    // Write enables of the image store.
    typedef struct packed {
        logic cur;
        logic tgt;
    } img_we_t;

    // Blend state flags.
    typedef struct packed {
        logic color;
        logic image;
        logic busy;
    } blend_flags_t;

    // Exact floor(x / 255) for any product of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ===== src/lic_scale.sv =====
// Shared scaling unit: registered a * b / 255 with truncation.
module lic_scale (
    input  logic       aclk,
    input  logic [7:0] a,
    input  logic [7:0] b,
    output logic [7:0] q
);

    logic [15:0] prod;
    logic [7:0]  q_reg;

    // One 8x8 product, divided by 255 without a divider.
    assign prod = 16'(a) * 16'(b);

    always_ff @(posedge aclk) begin
        q_reg <= lic_pkg::div255(prod);
    end

    assign q = q_reg;

endmodule

// ===== src/lic_div.sv =====
// Restoring divider that produces an 8-bit quotient, one bit per cycle.
module lic_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] num,
    input  logic [15:0] den,
    output logic        done,
    output logic [7:0]  quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [7:0]  low_reg;
    logic [15:0] den_reg;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    // The quotient fits in 8 bits because num < 256 * den, so the upper
    // 16 bits of num start as a partial remainder below den.
    assign trial = {rem_reg, low_reg[7]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= num[23:8];
                low_reg  <= num[7:0];
                den_reg  <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // Quotient bits shift in as the dividend bits shift out.
                rem_reg <= ge ? diff[15:0] : trial[15:0];
                low_reg <= {low_reg[6:0], ge};
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = low_reg;

endmodule

// ===== src/lic_img_store.sv =====
// Current and target image memories, one write and one registered read port each.
module lic_img_store #(
    parameter int CELLS = lic_pkg::CELLS_DEF
) (
    input  logic                     aclk,
    input  logic [$clog2(CELLS)-1:0] rd_addr,
    output logic [7:0]               cur_rd,
    output logic [7:0]               tgt_rd,
    input  lic_pkg::img_we_t         wr_en,
    input  logic [$clog2(CELLS)-1:0] wr_addr,
    input  logic [7:0]               cur_wdata,
    input  logic [7:0]               tgt_wdata
);

    logic [7:0] cur_mem [0:CELLS-1];
    logic [7:0] tgt_mem [0:CELLS-1];
    logic [7:0] cur_rd_reg;
    logic [7:0] tgt_rd_reg;

    // Both arrays share the address of each port.
    always_ff @(posedge aclk) begin
        if (wr_en.cur) begin
            cur_mem[wr_addr] <= cur_wdata;
        end
        if (wr_en.tgt) begin
            tgt_mem[wr_addr] <= tgt_wdata;
        end
        cur_rd_reg <= cur_mem[rd_addr];
        tgt_rd_reg <= tgt_mem[rd_addr];
    end

    assign cur_rd = cur_rd_reg;
    assign tgt_rd = tgt_rd_reg;

endmodule

// ===== src/led_image_color_crossfade.sv =====
// Top level of the LED image color crossfade engine: sequencer, state and result register.
//
// Usage: words enter on s_valid/s_ready/s_data and results leave on
// m_valid/m_ready/m_data, one result word per input word, in order.
// The max_brightness register is written with cfg_wr_en/cfg_wr_data.
// The block takes one word at a time; s_ready is high only when idle.
// Work per word, from acceptance to the result being loaded:
//   write target cell, start blend, tick while idle: straight to the result.
//   render cell: six passes through the shared scaling unit.
//   tick while blending both armed: the shared scaling unit
//   updates one value per cycle (three color values, then every image
//   cell), after the divider computes the blend factor (skipped for a zero duration).
// Ticks arrive once per millisecond, so the image sweep sets the pace.
// After reset the block clears both image memories, one cell per cycle,
// before s_ready rises; config writes are taken meanwhile.
// A result waits in the output register while m_ready is low; the next
// word may be accepted, and its result is held until the register frees.
module led_image_color_crossfade #(
    parameter int CELLS = lic_pkg::CELLS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lic_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lic_pkg::out_t m_data,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data
);

    localparam int IDX_W = $clog2(CELLS);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FACTOR,
        ST_DIV,
        ST_COLOR,
        ST_IMAGE,
        ST_DRAIN,
        ST_RREAD,
        ST_RMASK,
        ST_RSCALE,
        ST_RESULT
    } state_t;

    state_t                state_reg;
    state_t                sweep_first;
    logic [IDX_W-1:0]      cnt_reg;
    logic                  cnt_last;
    lic_pkg::in_t          item_reg;
    lic_pkg::out_t         res_reg;
    lic_pkg::out_t         res_init;
    lic_pkg::out_t         out_reg;
    logic                  m_valid_reg;
    lic_pkg::blend_flags_t flags_reg;
    logic [15:0]           duration_reg;
    logic [15:0]           elapsed_reg;
    logic [7:0]            factor_reg;
    logic [7:0]            cur_color_reg [0:2];
    logic [7:0]            tgt_color_reg [0:2];
    logic [7:0]            max_bright_reg;
    logic [7:0]            mask_reg;
    logic [7:0]            rtmp_reg [0:5];

    // Tick update pipeline: stage 1 holds the index being read, stage 2
    // waits for the scaling unit.
    logic                  p1_valid_reg;
    logic                  p1_color_reg;
    logic [IDX_W-1:0]      p1_idx_reg;
    logic                  p2_valid_reg;
    logic                  p2_color_reg;
    logic [IDX_W-1:0]      p2_idx_reg;
    logic [7:0]            p2_cur_reg;
    logic                  p2_up_reg;

    logic                  s_accept;
    logic                  in_range;
    logic                  item_in_range;
    logic [IDX_W-1:0]      rd_addr;
    logic [7:0]            cur_rd;
    logic [7:0]            tgt_rd;
    lic_pkg::img_we_t      wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [7:0]            cur_wdata;
    logic [7:0]            tgt_wdata;
    logic [1:0]            color_idx;
    logic [7:0]            color_rd;
    logic [7:0]            tgt_color_rd;
    logic [7:0]            cur_b;
    logic [7:0]            tgt_b;
    logic                  up_b;
    logic [7:0]            diff_b;
    logic [7:0]            new_val;
    logic [2:0]            step;
    logic [2:0]            rsel;
    logic [7:0]            scale_a;
    logic [7:0]            scale_b;
    logic [7:0]            scale_q;
    logic                  div_start;
    logic [23:0]           div_num;
    logic                  div_done;
    logic [7:0]            div_q;
    logic                  tick_fin;

    assign s_accept      = s_valid && s_ready;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_data        = out_reg;
    assign in_range      = 32'(s_data.cell_index) < CELLS;
    assign item_in_range = 32'(item_reg.cell_index) < CELLS;
    assign cnt_last      = (cnt_reg == IDX_W'(CELLS - 1));
    assign step          = cnt_reg[2:0];
    assign tick_fin      = (elapsed_reg >= duration_reg);

    // Result of a newly accepted word before any command fills it in.
    always_comb begin
        res_init          = '0;
        res_init.busy_res = flags_reg.busy || (s_data.func == lic_pkg::FUNC_START);
    end

    // First phase of the tick sweep depends on which blends are armed.
    always_comb begin
        priority if (flags_reg.color) begin
            sweep_first = ST_COLOR;
        end else if (flags_reg.image) begin
            sweep_first = ST_IMAGE;
        end else begin
            sweep_first = ST_DRAIN;
        end
    end

    // Image memory read address: the sweep index or the rendered cell.
    assign rd_addr = (state_reg == ST_IMAGE) ? cnt_reg : IDX_W'(item_reg.cell_index);

    // Image memory writes: clearing pass, tick write-back, target writes.
    always_comb begin
        wr_en     = '0;
        wr_addr   = cnt_reg;
        cur_wdata = '0;
        tgt_wdata = '0;
        priority if (state_reg == ST_CLEAR) begin
            wr_en.cur = 1'b1;
            wr_en.tgt = 1'b1;
        end else if (p2_valid_reg && !p2_color_reg) begin
            wr_en.cur = 1'b1;
            wr_addr   = p2_idx_reg;
            cur_wdata = new_val;
        end else if (s_accept && s_data.func == lic_pkg::FUNC_WRITE && in_range) begin
            wr_en.tgt = 1'b1;
            wr_addr   = IDX_W'(s_data.cell_index);
            tgt_wdata = s_data.cell_lit ? lic_pkg::FULL_SCALE : 8'd0;
        end else begin
            wr_en = '0;
        end
    end

    lic_img_store #(
        .CELLS(CELLS)
    ) u_img_store (
        .aclk     (aclk),
        .rd_addr  (rd_addr),
        .cur_rd   (cur_rd),
        .tgt_rd   (tgt_rd),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .cur_wdata(cur_wdata),
        .tgt_wdata(tgt_wdata)
    );

    // One read port on the color registers, shared by render and tick.
    always_comb begin
        priority if (state_reg == ST_RSCALE && step < 3'd3) begin
            color_idx = step[1:0];
        end else if (p1_color_reg) begin
            color_idx = p1_idx_reg[1:0];
        end else begin
            color_idx = 2'd0;
        end
    end

    assign color_rd     = cur_color_reg[color_idx];
    assign tgt_color_rd = tgt_color_reg[color_idx];

    // Stage 2 input: distance from the current value to its target.
    assign cur_b  = p1_color_reg ? color_rd : cur_rd;
    assign tgt_b  = p1_color_reg ? tgt_color_rd : tgt_rd;
    assign up_b   = (tgt_b >= cur_b);
    assign diff_b = up_b ? (tgt_b - cur_b) : (cur_b - tgt_b);

    // Write-back value: move by the scaled distance toward the target.
    assign new_val = p2_up_reg ? (p2_cur_reg + scale_q) : (p2_cur_reg - scale_q);

    // Scaling unit operands. Render runs six products: three colors by the
    // mask, then those three by the global brightness.
    assign rsel = (step >= 3'd3) ? (step - 3'd3) : 3'd0;

    always_comb begin
        if (state_reg == ST_RSCALE) begin
            if (step < 3'd3) begin
                scale_a = color_rd;
                scale_b = mask_reg;
            end else begin
                scale_a = rtmp_reg[rsel];
                scale_b = max_bright_reg;
            end
        end else begin
            scale_a = diff_b;
            scale_b = factor_reg;
        end
    end

    lic_scale u_scale (
        .aclk(aclk),
        .a   (scale_a),
        .b   (scale_b),
        .q   (scale_q)
    );

    // Factor numerator elapsed * 255 as a shift and subtract.
    assign div_num   = {elapsed_reg, 8'd0} - {8'd0, elapsed_reg};
    assign div_start = (state_reg == ST_FACTOR) && (duration_reg != 16'd0);

    lic_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (duration_reg),
        .done   (div_done),
        .quo    (div_q)
    );

    // Sequencer, blend state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            cnt_reg          <= '0;
            m_valid_reg      <= 1'b0;
            flags_reg        <= '0;
            duration_reg     <= '0;
            elapsed_reg      <= '0;
            max_bright_reg   <= lic_pkg::FULL_SCALE;
            cur_color_reg[0] <= 8'd0;
            cur_color_reg[1] <= 8'd0;
            cur_color_reg[2] <= lic_pkg::FULL_SCALE;
            tgt_color_reg[0] <= 8'd0;
            tgt_color_reg[1] <= 8'd0;
            tgt_color_reg[2] <= 8'd0;
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_bright_reg <= cfg_wr_data;
            end

            // Result valid rises when a result is loaded and falls when taken.
            if (state_reg == ST_RESULT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Pipeline advance.
            p1_valid_reg <= (state_reg == ST_COLOR) || (state_reg == ST_IMAGE);
            p2_valid_reg <= p1_valid_reg;
            p2_color_reg <= p1_color_reg;
            p2_idx_reg   <= p1_idx_reg;
            p2_cur_reg   <= cur_b;
            p2_up_reg    <= up_b;
            if (p2_valid_reg && p2_color_reg) begin
                cur_color_reg[p2_idx_reg[1:0]] <= new_val;
            end

            // Render products are captured from the scaling unit in the cycle after they were issued.
            if (state_reg == ST_RSCALE && step != 3'd0) begin
                rtmp_reg[step - 3'd1] <= scale_q;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    if (cnt_last) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + IDX_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        res_reg  <= res_init;
                        unique case (s_data.func)
                            lic_pkg::FUNC_WRITE: begin
                                state_reg <= ST_RESULT;
                            end
                            lic_pkg::FUNC_START: begin
                                duration_reg    <= s_data.duration_ms;
                                elapsed_reg     <= '0;
                                flags_reg.busy  <= 1'b1;
                                flags_reg.image <= flags_reg.image || s_data.blend_image;
                                flags_reg.color <= flags_reg.color || s_data.blend_color;
                                if (s_data.blend_color) begin
                                    tgt_color_reg[0] <= s_data.target_red;
                                    tgt_color_reg[1] <= s_data.target_green;
                                    tgt_color_reg[2] <= s_data.target_blue;
                                end
                                state_reg <= ST_RESULT;
                            end
                            lic_pkg::FUNC_TICK: begin
                                if (flags_reg.busy) begin
                                    if (elapsed_reg < duration_reg) begin
                                        elapsed_reg <= elapsed_reg + 16'd1;
                                    end
                                    state_reg <= ST_FACTOR;
                                end else begin
                                    state_reg <= ST_RESULT;
                                end
                            end
                            lic_pkg::FUNC_RENDER: begin
                                state_reg <= ST_RREAD;
                            end
                            default: begin
                                state_reg <= ST_RESULT;
                            end
                        endcase
                    end
                end
                ST_FACTOR: begin
                    // A zero duration blends fully at once.
                    if (duration_reg == 16'd0) begin
                        factor_reg <= lic_pkg::FULL_SCALE;
                        cnt_reg    <= '0;
                        state_reg  <= sweep_first;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        factor_reg <= div_q;
                        cnt_reg    <= '0;
                        state_reg  <= sweep_first;
                    end
                end
                ST_COLOR: begin
                    p1_color_reg <= 1'b1;
                    p1_idx_reg   <= cnt_reg;
                    if (cnt_reg == IDX_W'(2)) begin
                        cnt_reg   <= '0;
                        state_reg <= flags_reg.image ? ST_IMAGE : ST_DRAIN;
                    end else begin
                        cnt_reg <= cnt_reg + IDX_W'(1);
                    end
                end
                ST_IMAGE: begin
                    p1_color_reg <= 1'b0;
                    p1_idx_reg   <= cnt_reg;
                    if (cnt_last) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        cnt_reg <= cnt_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    // Once every write-back is done, close the tick. At the
                    // end of the blend the factor is full scale, so every
                    // armed value already equals its target.
                    if (!p1_valid_reg && !p2_valid_reg) begin
                        res_reg.blend_factor <= factor_reg;
                        res_reg.finished     <= tick_fin;
                        res_reg.busy_res     <= !tick_fin;
                        if (tick_fin) begin
                            flags_reg <= '0;
                        end
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RREAD: begin
                    state_reg <= ST_RMASK;
                end
                ST_RMASK: begin
                    mask_reg  <= flags_reg.image ? cur_rd : lic_pkg::FULL_SCALE;
                    cnt_reg   <= '0;
                    state_reg <= ST_RSCALE;
                end
                ST_RSCALE: begin
                    if (step == 3'd6) begin
                        res_reg.red   <= item_in_range ? rtmp_reg[3] : 8'd0;
                        res_reg.green <= item_in_range ? rtmp_reg[4] : 8'd0;
                        res_reg.blue  <= item_in_range ? scale_q : 8'd0;
                        cnt_reg       <= '0;
                        state_reg     <= ST_RESULT;
                    end else begin
                        cnt_reg <= cnt_reg + IDX_W'(1);
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg   <= res_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // No tick write-back may still be in flight when a new word can enter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!p1_valid_reg && !p2_valid_reg))
        else $error("tick pipeline active while accepting a word");

    // A tick that completes the blend leaves the block not busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.finished) |-> !m_data.busy_res)
        else $error("finished result still reports a blend in progress");

    // Only tick results carry a factor, and those carry no color.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.blend_factor != 8'd0) |->
        (m_data.red == 8'd0 && m_data.green == 8'd0 && m_data.blue == 8'd0))
        else $error("result carries both a factor and a color");

    // The divider only completes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the factor wait");
`endif

endmodule
